### rtl/core/bft_pkg.sv
package bft_pkg;

   localparam int PROG_DEPTH = 4096;
   localparam int PROG_AW    = $clog2(PROG_DEPTH);
   localparam int PC_W       = PROG_AW + 1;
   localparam int TAPE_CELLS = 512;
   localparam int TAPE_AW    = $clog2(TAPE_CELLS);
   localparam int CELL_BITS  = 32;
   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int OP_W       = 4;
   localparam int STATUS_W   = 3;
   localparam int ASCII_LIMIT = 128;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_STEP   = 2'd1,
      CMD_REWIND = 2'd2,
      CMD_ERASE  = 2'd3
   } cmd_type;

   typedef enum logic [OP_W-1:0] {
      OP_NOP   = 4'd0,
      OP_INC   = 4'd1,
      OP_DEC   = 4'd2,
      OP_RIGHT = 4'd3,
      OP_LEFT  = 4'd4,
      OP_OUT   = 4'd5,
      OP_IN    = 4'd6,
      OP_OPEN  = 4'd7,
      OP_CLOSE = 4'd8
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK          = 3'd0,
      STS_END         = 3'd1,
      STS_PTR_HIGH    = 3'd2,
      STS_PTR_LOW     = 3'd3,
      STS_NON_ASCII   = 3'd4,
      STS_STRAY_CLOSE = 3'd5,
      STS_STORE_FULL  = 3'd6,
      STS_UNBALANCED  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      CS_WIPE,
      CS_IDLE,
      CS_DECODE,
      CS_LINK1,
      CS_LINK2,
      CS_EXEC,
      CS_REWIND
   } ctrl_state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CAPTURE,
      ACT_REPLY,
      ACT_APPEND,
      ACT_LINK1,
      ACT_LINK2,
      ACT_EXEC,
      ACT_ERASE,
      ACT_CLEAR,
      ACT_CLEAR_END,
      ACT_WIPE_END
   } action_type;

   typedef struct packed {
      action_type act;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    stop;
      logic    is_close;
      logic    clear_last;
   } stat_type;

   function automatic opcode_type encode_char(input logic [CHAR_W-1:0] c);
      opcode_type op;
      case (c)
         8'h2B:   op = OP_INC;
         8'h2D:   op = OP_DEC;
         8'h3E:   op = OP_RIGHT;
         8'h3C:   op = OP_LEFT;
         8'h2E:   op = OP_OUT;
         8'h2C:   op = OP_IN;
         8'h5B:   op = OP_OPEN;
         8'h5D:   op = OP_CLOSE;
         default: op = OP_NOP;
      endcase
      return op;
   endfunction

endpackage

### rtl/core/bft_ctrl.sv
module bft_ctrl
   import bft_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctl_type  ctl,
   output logic     busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_WIPE: begin
            if (stat.clear_last) state_in = CS_IDLE;
         end
         CS_IDLE: begin
            if (start) state_in = CS_DECODE;
         end
         CS_DECODE: begin
            case (stat.cmd)
               CMD_APPEND: state_in = (!stat.stop && stat.is_close) ? CS_LINK1 : CS_IDLE;
               CMD_STEP:   state_in = stat.stop ? CS_IDLE : CS_EXEC;
               CMD_REWIND: state_in = CS_REWIND;
               default:    state_in = CS_IDLE;
            endcase
         end
         CS_LINK1: state_in = CS_LINK2;
         CS_LINK2: state_in = CS_IDLE;
         CS_EXEC:  state_in = CS_IDLE;
         CS_REWIND: begin
            if (stat.clear_last) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      ctl.act = ACT_NONE;
      case (state_ff)
         CS_WIPE:  ctl.act = stat.clear_last ? ACT_WIPE_END : ACT_CLEAR;
         CS_IDLE: begin
            if (start) ctl.act = ACT_CAPTURE;
         end
         CS_DECODE: begin
            case (stat.cmd)
               CMD_APPEND: begin
                  if (stat.stop) ctl.act = ACT_REPLY;
                  else if (!stat.is_close) ctl.act = ACT_APPEND;
               end
               CMD_STEP: begin
                  if (stat.stop) ctl.act = ACT_REPLY;
               end
               CMD_ERASE: ctl.act = ACT_ERASE;
               default:   ctl.act = ACT_NONE;
            endcase
         end
         CS_LINK1:  ctl.act = ACT_LINK1;
         CS_LINK2:  ctl.act = ACT_LINK2;
         CS_EXEC:   ctl.act = ACT_EXEC;
         CS_REWIND: ctl.act = stat.clear_last ? ACT_CLEAR_END : ACT_CLEAR;
         default:   ctl.act = ACT_NONE;
      endcase
   end

   assign busy = (state_ff != CS_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/bft_datapath.sv
module bft_datapath
   import bft_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   output stat_type             stat,
   input  logic [1:0]           req_cmd,
   input  logic [CHAR_W-1:0]    req_program_char,
   input  logic [VALUE_W-1:0]   req_input_value,
   output logic                 rsp_valid,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_char_valid,
   output logic [CHAR_W-1:0]    rsp_char_out,
   output logic [PC_W-1:0]      rsp_next_pc,
   output logic [TAPE_AW-1:0]   rsp_cell_index
);

   logic [OP_W-1:0]      prog_mem  [PROG_DEPTH];
   logic [PROG_AW-1:0]   match_mem [PROG_DEPTH];
   logic [PROG_AW-1:0]   stack_mem [PROG_DEPTH];
   logic [CELL_BITS-1:0] tape_mem  [TAPE_CELLS];

   logic [OP_W-1:0]      prog_rd_ff;
   logic [PROG_AW-1:0]   match_rd_ff;
   logic [PROG_AW-1:0]   stack_rd_ff;
   logic [CELL_BITS-1:0] tape_rd_ff;

   cmd_type              cmd_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic [CELL_BITS-1:0] value_ff;
   logic [PC_W-1:0]      len_ff, len_in;
   logic [PC_W-1:0]      depth_ff, depth_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [TAPE_AW-1:0]   ptr_ff, ptr_in;
   status_type           run_ff, run_in;
   logic [TAPE_AW-1:0]   clr_ff, clr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_char_valid_ff, rsp_char_valid_in;
   logic [CHAR_W-1:0]    rsp_char_out_ff, rsp_char_out_in;
   logic [PC_W-1:0]      rsp_next_pc_ff;
   logic [TAPE_AW-1:0]   rsp_cell_index_ff;

   opcode_type           char_op;
   opcode_type           exec_op;
   status_type           check_code;
   logic [PROG_AW-1:0]   stack_top;
   logic [PC_W-1:0]      match_next;

   logic                 prog_we;
   logic                 stack_we;
   logic                 match_we;
   logic [PROG_AW-1:0]   match_wa;
   logic [PROG_AW-1:0]   match_wd;
   logic                 tape_we;
   logic [TAPE_AW-1:0]   tape_wa;
   logic [CELL_BITS-1:0] tape_wd;

   assign char_op    = encode_char(char_ff);
   assign exec_op    = opcode_type'(prog_rd_ff);
   assign stack_top  = PROG_AW'(depth_ff - PC_W'(1));
   assign match_next = {1'b0, match_rd_ff} + PC_W'(1);

   always_comb begin
      check_code = STS_OK;
      if (cmd_ff == CMD_APPEND) begin
         if (len_ff >= PC_W'(PROG_DEPTH)) check_code = STS_STORE_FULL;
         else if (char_op == OP_CLOSE && depth_ff == '0) check_code = STS_STRAY_CLOSE;
      end else begin
         if (run_ff != STS_OK) check_code = run_ff;
         else if (depth_ff != '0) check_code = STS_UNBALANCED;
         else if (pc_ff >= len_ff) check_code = STS_END;
      end
   end

   assign stat.cmd        = cmd_ff;
   assign stat.stop       = (check_code != STS_OK);
   assign stat.is_close   = (char_op == OP_CLOSE);
   assign stat.clear_last = (clr_ff == TAPE_AW'(TAPE_CELLS - 1));

   always_comb begin
      len_in            = len_ff;
      depth_in          = depth_ff;
      pc_in             = pc_ff;
      ptr_in            = ptr_ff;
      run_in            = run_ff;
      clr_in            = clr_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = STS_OK;
      rsp_char_valid_in = 1'b0;
      rsp_char_out_in   = '0;
      prog_we           = 1'b0;
      stack_we          = 1'b0;
      match_we          = 1'b0;
      match_wa          = len_ff[PROG_AW-1:0];
      match_wd          = stack_rd_ff;
      tape_we           = 1'b0;
      tape_wa           = ptr_ff;
      tape_wd           = tape_rd_ff;
      case (ctl.act)
         ACT_REPLY: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = check_code;
         end
         ACT_APPEND: begin
            prog_we      = 1'b1;
            stack_we     = (char_op == OP_OPEN);
            if (char_op == OP_OPEN) depth_in = depth_ff + PC_W'(1);
            len_in       = len_ff + PC_W'(1);
            rsp_valid_in = 1'b1;
         end
         ACT_LINK1: begin
            match_we = 1'b1;
         end
         ACT_LINK2: begin
            match_we     = 1'b1;
            match_wa     = stack_rd_ff;
            match_wd     = len_ff[PROG_AW-1:0];
            prog_we      = 1'b1;
            depth_in     = depth_ff - PC_W'(1);
            len_in       = len_ff + PC_W'(1);
            rsp_valid_in = 1'b1;
         end
         ACT_EXEC: begin
            rsp_valid_in = 1'b1;
            pc_in        = pc_ff + PC_W'(1);
            case (exec_op)
               OP_INC: begin
                  tape_we = 1'b1;
                  tape_wd = tape_rd_ff + CELL_BITS'(1);
               end
               OP_DEC: begin
                  tape_we = 1'b1;
                  tape_wd = tape_rd_ff - CELL_BITS'(1);
               end
               OP_IN: begin
                  tape_we = 1'b1;
                  tape_wd = value_ff;
               end
               OP_RIGHT: begin
                  if (ptr_ff == TAPE_AW'(TAPE_CELLS - 1)) begin
                     pc_in         = pc_ff;
                     run_in        = STS_PTR_HIGH;
                     rsp_status_in = STS_PTR_HIGH;
                  end else begin
                     ptr_in = ptr_ff + TAPE_AW'(1);
                  end
               end
               OP_LEFT: begin
                  if (ptr_ff == '0) begin
                     pc_in         = pc_ff;
                     run_in        = STS_PTR_LOW;
                     rsp_status_in = STS_PTR_LOW;
                  end else begin
                     ptr_in = ptr_ff - TAPE_AW'(1);
                  end
               end
               OP_OUT: begin
                  if (!tape_rd_ff[CELL_BITS-1] && tape_rd_ff >= CELL_BITS'(ASCII_LIMIT)) begin
                     pc_in         = pc_ff;
                     run_in        = STS_NON_ASCII;
                     rsp_status_in = STS_NON_ASCII;
                  end else begin
                     rsp_char_valid_in = 1'b1;
                     rsp_char_out_in   = tape_rd_ff[CHAR_W-1:0];
                  end
               end
               OP_OPEN: begin
                  if (tape_rd_ff == '0) pc_in = match_next;
               end
               OP_CLOSE: begin
                  if (tape_rd_ff != '0) pc_in = match_next;
               end
               default: pc_in = pc_ff + PC_W'(1);
            endcase
         end
         ACT_ERASE: begin
            len_in       = '0;
            depth_in     = '0;
            pc_in        = '0;
            rsp_valid_in = 1'b1;
         end
         ACT_CLEAR: begin
            tape_we = 1'b1;
            tape_wa = clr_ff;
            tape_wd = '0;
            clr_in  = clr_ff + TAPE_AW'(1);
         end
         ACT_CLEAR_END: begin
            tape_we      = 1'b1;
            tape_wa      = clr_ff;
            tape_wd      = '0;
            clr_in       = '0;
            pc_in        = '0;
            ptr_in       = '0;
            run_in       = STS_OK;
            rsp_valid_in = 1'b1;
         end
         ACT_WIPE_END: begin
            tape_we = 1'b1;
            tape_wa = clr_ff;
            tape_wd = '0;
            clr_in  = '0;
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (prog_we) prog_mem[len_ff[PROG_AW-1:0]] <= char_op;
      prog_rd_ff <= prog_mem[pc_ff[PROG_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (match_we) match_mem[match_wa] <= match_wd;
      match_rd_ff <= match_mem[pc_ff[PROG_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[depth_ff[PROG_AW-1:0]] <= len_ff[PROG_AW-1:0];
      stack_rd_ff <= stack_mem[stack_top];
   end

   always_ff @(posedge clock) begin
      if (tape_we) tape_mem[tape_wa] <= tape_wd;
      tape_rd_ff <= tape_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (ctl.act == ACT_CAPTURE) begin
         cmd_ff   <= cmd_type'(req_cmd);
         char_ff  <= req_program_char;
         value_ff <= req_input_value[CELL_BITS-1:0];
      end
      rsp_status_ff     <= rsp_status_in;
      rsp_char_valid_ff <= rsp_char_valid_in;
      rsp_char_out_ff   <= rsp_char_out_in;
      rsp_next_pc_ff    <= pc_in;
      rsp_cell_index_ff <= ptr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         depth_ff     <= '0;
         pc_ff        <= '0;
         ptr_ff       <= '0;
         run_ff       <= STS_OK;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         depth_ff     <= depth_in;
         pc_ff        <= pc_in;
         ptr_ff       <= ptr_in;
         run_ff       <= run_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_char_valid = rsp_char_valid_ff;
   assign rsp_char_out   = rsp_char_out_ff;
   assign rsp_next_pc    = rsp_next_pc_ff;
   assign rsp_cell_index = rsp_cell_index_ff;

endmodule

### rtl/core/bf_tape_machine_top.sv
// The response strobe is registered: it rises after the decode state for an append, an
// erase or a refused step, after the execute state for an executed step, after the link
// states for a closing bracket and after the tape sweep for a rewind. A request is taken only
// in idle, so a new request waits until the last is through, held by the registered memory
// reads and the cell-by-cell tape sweep. Reset clears all control state, then busy stays high
// while the tape is swept to zero one cell a cycle; the receiver cannot stall responses.
module bf_tape_machine_top
   import bft_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic [CHAR_W-1:0]          req_program_char,
   input  logic signed [VALUE_W-1:0]  req_input_value,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_char_valid,
   output logic [CHAR_W-1:0]          rsp_char_out,
   output logic [PC_W-1:0]            rsp_next_pc,
   output logic [TAPE_AW-1:0]         rsp_cell_index
);

   ctl_type  ctl;
   stat_type stat;

   bft_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctl   (ctl),
      .busy  (busy)
   );

   bft_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_program_char (req_program_char),
      .req_input_value  (req_input_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_char_out     (rsp_char_out),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_cell_index   (rsp_cell_index)
   );

endmodule

### tb/tb_bf_tape_machine_top.sv
module tb_bf_tape_machine_top
   import bft_pkg::*;
();

   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      status_type          status;
      logic                char_valid;
      logic [CHAR_W-1:0]   char_out;
      logic [PC_W-1:0]     next_pc;
      logic [TAPE_AW-1:0]  cell_index;
   } tape_reply_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_cmd = CMD_APPEND;
   logic [CHAR_W-1:0]          req_program_char = '0;
   logic signed [VALUE_W-1:0]  req_input_value = '0;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_char_valid;
   logic [CHAR_W-1:0]          rsp_char_out;
   logic [PC_W-1:0]            rsp_next_pc;
   logic [TAPE_AW-1:0]         rsp_cell_index;

   // Mirror of the machine state, advanced once per accepted request.
   opcode_type           prog_ops [PROG_DEPTH];
   logic [PROG_AW-1:0]   bracket_pair [PROG_DEPTH];
   int                   open_stack [PROG_DEPTH];
   logic [CELL_BITS-1:0] tape_cells [TAPE_CELLS];
   int                   open_count = 0;
   int                   prog_len = 0;
   int                   prog_pc = 0;
   int                   tape_ptr = 0;
   status_type           sticky_fault = STS_OK;

   tape_reply_type replies_due [$];
   int             mismatches = 0;
   int             quiet_cycles = 0;
   int             items_sent = 0;
   int             idle_pct = 29;

   bf_tape_machine_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_program_char (req_program_char),
      .req_input_value  (req_input_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_char_out     (rsp_char_out),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_cell_index   (rsp_cell_index)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic opcode_type op_for_char(input logic [CHAR_W-1:0] ch);
      case (ch)
         "+":     return OP_INC;
         "-":     return OP_DEC;
         ">":     return OP_RIGHT;
         "<":     return OP_LEFT;
         ".":     return OP_OUT;
         ",":     return OP_IN;
         "[":     return OP_OPEN;
         "]":     return OP_CLOSE;
         default: return OP_NOP;
      endcase
   endfunction

   function automatic tape_reply_type advance_machine(input cmd_type cmd,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [VALUE_W-1:0] value);
      tape_reply_type       r;
      opcode_type           op;
      logic [CELL_BITS-1:0] cur_cell;
      int                   open_at;
      r.status = STS_OK;
      r.char_valid = 1'b0;
      r.char_out = '0;
      case (cmd)
         CMD_APPEND: begin
            op = op_for_char(ch);
            if (prog_len >= PROG_DEPTH) begin
               r.status = STS_STORE_FULL;
            end else if (op == OP_CLOSE && open_count == 0) begin
               r.status = STS_STRAY_CLOSE;
            end else begin
               if (op == OP_CLOSE) begin
                  open_count--;
                  open_at = open_stack[open_count];
                  bracket_pair[prog_len] = PROG_AW'(open_at);
                  bracket_pair[open_at] = PROG_AW'(prog_len);
               end else if (op == OP_OPEN) begin
                  open_stack[open_count] = prog_len;
                  open_count++;
               end
               prog_ops[prog_len] = op;
               prog_len++;
            end
         end
         CMD_STEP: begin
            if (sticky_fault != STS_OK) begin
               r.status = sticky_fault;
            end else if (open_count != 0) begin
               r.status = STS_UNBALANCED;
            end else if (prog_pc >= prog_len) begin
               r.status = STS_END;
            end else begin
               cur_cell = tape_cells[tape_ptr];
               case (prog_ops[prog_pc])
                  OP_INC: tape_cells[tape_ptr] = cur_cell + 1'b1;
                  OP_DEC: tape_cells[tape_ptr] = cur_cell - 1'b1;
                  OP_RIGHT: begin
                     if (tape_ptr == TAPE_CELLS - 1) r.status = STS_PTR_HIGH;
                     else tape_ptr++;
                  end
                  OP_LEFT: begin
                     if (tape_ptr == 0) r.status = STS_PTR_LOW;
                     else tape_ptr--;
                  end
                  OP_OUT: begin
                     if (!cur_cell[CELL_BITS-1] && cur_cell >= ASCII_LIMIT) begin
                        r.status = STS_NON_ASCII;
                     end else begin
                        r.char_valid = 1'b1;
                        r.char_out = cur_cell[CHAR_W-1:0];
                     end
                  end
                  OP_IN: tape_cells[tape_ptr] = value[CELL_BITS-1:0];
                  OP_OPEN: begin
                     if (cur_cell == 0) prog_pc = bracket_pair[prog_pc];
                  end
                  OP_CLOSE: begin
                     if (cur_cell != 0) prog_pc = bracket_pair[prog_pc];
                  end
                  default: ;
               endcase
               if (r.status == STS_OK) prog_pc++;
               else sticky_fault = r.status;
            end
         end
         CMD_REWIND: begin
            prog_pc = 0;
            tape_ptr = 0;
            foreach (tape_cells[i]) tape_cells[i] = '0;
            sticky_fault = STS_OK;
         end
         default: begin
            prog_len = 0;
            open_count = 0;
            prog_pc = 0;
         end
      endcase
      r.next_pc = PC_W'(prog_pc);
      r.cell_index = TAPE_AW'(tape_ptr);
      return r;
   endfunction

   always @(posedge clock) begin : reply_monitor
      tape_reply_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected reply: status %0d char %0b/%h pc %0d cell %0d",
                           rsp_status, rsp_char_valid, rsp_char_out, rsp_next_pc,
                           rsp_cell_index);
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status || rsp_char_valid !== want.char_valid ||
                   rsp_char_out !== want.char_out || rsp_next_pc !== want.next_pc ||
                   rsp_cell_index !== want.cell_index) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"reply mismatch: expected status %0d char %0b/%h pc %0d ",
                               "cell %0d, got status %0d char %0b/%h pc %0d cell %0d"},
                              want.status, want.char_valid, want.char_out, want.next_pc,
                              want.cell_index, rsp_status, rsp_char_valid, rsp_char_out,
                              rsp_next_pc, rsp_cell_index);
               end
            end
         end
         if (start && !busy)
            replies_due.push_back(advance_machine(cmd_type'(req_cmd), req_program_char,
                                                  req_input_value));
      end
   end

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 || (start && busy === 1'b0)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_request(input cmd_type cmd,
                               input logic [CHAR_W-1:0] ch = '0,
                               input logic [VALUE_W-1:0] value = '0);
      if ($urandom_range(99) < idle_pct) begin
         repeat ($urandom_range(1, 6)) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_program_char <= ch;
      req_input_value <= value;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      do @(negedge clock); while (replies_due.size() != 0);
      @(posedge clock);
   endtask

   task automatic append_text(input string text);
      for (int i = 0; i < text.len(); i++) send_request(CMD_APPEND, text[i]);
   endtask

   task automatic run_steps(input int count, input logic [VALUE_W-1:0] value = '0);
      repeat (count) send_request(CMD_STEP, '0, value);
   endtask

   function automatic logic [VALUE_W-1:0] pick_input_value();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom_range(0, 127);
      if (r < 75) return VALUE_W'(0 - int'($urandom_range(1, 200)));
      return $urandom();
   endfunction

   task automatic test_empty_machine();
      send_request(CMD_STEP);
      send_request(CMD_ERASE);
      send_request(CMD_REWIND);
   endtask

   task automatic test_cell_wrap();
      append_text("-+,+,-");
      send_request(CMD_STEP);
      send_request(CMD_STEP);
      send_request(CMD_STEP, '0, 32'h7FFF_FFFF);
      send_request(CMD_STEP);
      send_request(CMD_STEP, '0, 32'h8000_0000);
      run_steps(2);
   endtask

   task automatic test_output_chars();
      send_request(CMD_ERASE);
      send_request(CMD_REWIND);
      append_text(",.,.,.,.");
      send_request(CMD_STEP, '0, 32'd127);
      send_request(CMD_STEP);
      send_request(CMD_STEP, '0, 32'hFFFF_FFFF);
      send_request(CMD_STEP);
      send_request(CMD_STEP, '0, 32'hFFFF_FF80);
      send_request(CMD_STEP);
      send_request(CMD_STEP, '0, 32'd128);
      run_steps(2);
      send_request(CMD_REWIND);
   endtask

   task automatic test_pointer_faults();
      send_request(CMD_ERASE);
      append_text("<");
      run_steps(2);
      send_request(CMD_REWIND);
      send_request(CMD_ERASE);
      // The loop moves 32 cells, marks the cell and repeats until it runs off the tape.
      append_text("+[");
      repeat (32) send_request(CMD_APPEND, ">");
      append_text("+]");
      run_steps(546);
      send_request(CMD_REWIND);
   endtask

   task automatic test_bracket_rules();
      send_request(CMD_ERASE);
      append_text("]");
      append_text("[+");
      send_request(CMD_STEP);
      append_text("]+[-]");
      run_steps(4);
      send_request(CMD_REWIND);
      append_text("]");
      run_steps(12);
   endtask

   task automatic test_erase_keeps_tape();
      send_request(CMD_ERASE);
      send_request(CMD_REWIND);
      append_text(",>");
      send_request(CMD_STEP, '0, 32'd5);
      send_request(CMD_STEP);
      send_request(CMD_ERASE);
      append_text("<.");
      run_steps(3);
   endtask

   task automatic run_random_program();
      int         len;
      int         depth;
      int         r;
      bit         tidy;
      logic [7:0] ch;
      tidy = ($urandom_range(99) < 80);
      if ($urandom_range(99) < 85 || prog_len > 3000) send_request(CMD_ERASE);
      len = $urandom_range(2, 24);
      depth = 0;
      repeat (len) begin
         r = $urandom_range(99);
         ch = (r < 14) ? "+" : (r < 26) ? "-" : (r < 38) ? ">" : (r < 48) ? "<" :
              (r < 60) ? "." : (r < 70) ? "," : (r < 80) ? "[" : (r < 90) ? "]" :
              8'($urandom_range(0, 255));
         if (op_for_char(ch) == OP_CLOSE) begin
            if (depth > 0) depth--;
            else if (tidy) ch = "+";
         end else if (op_for_char(ch) == OP_OPEN) begin
            depth++;
         end
         send_request(CMD_APPEND, ch);
      end
      if (tidy) repeat (depth) send_request(CMD_APPEND, "]");
      if ($urandom_range(99) < 70) send_request(CMD_REWIND);
      repeat ($urandom_range(4, 40)) begin
         if ($urandom_range(99) < 5)
            send_request(cmd_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         $urandom());
         else
            send_request(CMD_STEP, 8'($urandom_range(0, 255)), pick_input_value());
      end
      if ($urandom_range(99) < 20) wait_drain();
   endtask

   task automatic test_random_programs();
      int phase_idle [3] = '{29, 47, 0};
      int target;
      for (int p = 0; p < 3; p++) begin
         idle_pct = phase_idle[p];
         target = items_sent + 180;
         while (items_sent < target) run_random_program();
      end
   endtask

   initial begin
      foreach (tape_cells[i]) tape_cells[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_machine();
      test_cell_wrap();
      test_output_chars();
      test_pointer_faults();
      test_bracket_rules();
      test_erase_keeps_tape();
      wait_drain();
      test_random_programs();
      wait_drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/bft_pkg.sv
rtl/core/bft_ctrl.sv
rtl/core/bft_datapath.sv
rtl/core/bf_tape_machine_top.sv
tb/tb_bf_tape_machine_top.sv
